// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file uer_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uer_pkg.sv =====
// shared types and constants for the ultrasonic echo ranger
// no dependencies
`timescale 1ns / 1ps

package uer_pkg;

    localparam int SUB_COUNT_BITS_DEF = 8;
    localparam int OVF_W              = 10;
    localparam int DIST_W             = 10;
    localparam int SCALE_W            = 16;
    localparam int TRIG_W             = 16;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int SCALE_SHIFT        = 24;

    localparam logic [DIST_W-1:0]  DIST_MAX      = 10'd1023;
    localparam logic [OVF_W-1:0]   TIMEOUT_RST   = 10'd730;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 16'd17986;
    localparam logic [TRIG_W-1:0]  TRIG_RST      = 16'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd2;

    typedef struct packed {
        logic [OVF_W-1:0]   timeout_overflows;
        logic [SCALE_W-1:0] scale_reciprocal;
        logic [TRIG_W-1:0]  trigger_ticks;
    } cfg_t;

    typedef struct packed {
        logic              trigger_out;
        logic              busy_res;
        logic              distance_valid;
        logic [DIST_W-1:0] distance_cm;
        logic              timed_out;
    } res_t;

endpackage

// ===== rtl/uer_core.sv =====
// per-tick state update: echo edge timing, free-running timer, trigger pulse
// depends on uer_pkg
`timescale 1ns / 1ps

module uer_core
    import uer_pkg::*;
#(
    parameter int SUB_COUNT_BITS = SUB_COUNT_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic echo_level,
    input  logic start_request,
    input  cfg_t cfg,
    output res_t res
);

    localparam int TW = OVF_W + SUB_COUNT_BITS;
    localparam int PW = TW + SCALE_W;
    localparam int DW = PW - SCALE_SHIFT;
    localparam int CW = (DW > DIST_W) ? DW : DIST_W;

    logic [SUB_COUNT_BITS-1:0] sub_reg, sub_next;
    logic [OVF_W-1:0]          ovf_reg, ovf_next;
    logic                      busy_reg, busy_next;
    logic                      pulse_reg, pulse_next;
    logic                      prev_echo_reg;
    logic [TRIG_W-1:0]         trig_left_reg, trig_left_next;
    logic [DIST_W-1:0]         dist_reg, dist_next;

    logic [TW-1:0]     ticks;
    logic [PW-1:0]     prod;
    logic [DW-1:0]     dist_raw;
    logic [DIST_W-1:0] dist_sat;

    assign ticks    = {ovf_reg, sub_reg};
    assign prod     = PW'(ticks) * PW'(cfg.scale_reciprocal);
    assign dist_raw = prod[PW-1:SCALE_SHIFT];
    assign dist_sat = (CW'(dist_raw) > CW'(DIST_MAX)) ? DIST_MAX : DIST_W'(dist_raw);

    always_comb
    begin
        logic                      edge_hit;
        logic [SUB_COUNT_BITS-1:0] sub_a;
        logic [OVF_W-1:0]          ovf_a;
        logic [OVF_W:0]            ovf_inc;
        logic                      wrap;
        logic                      tmo;
        logic                      trig;
        logic                      meas;
        logic [TRIG_W-1:0]         tl_a;

        edge_hit = (echo_level != prev_echo_reg) && busy_reg;
        meas     = edge_hit && pulse_reg;
        sub_a    = sub_reg;
        ovf_a    = ovf_reg;
        pulse_next = pulse_reg;
        dist_next  = dist_reg;

        // echo edges
        if (edge_hit)
        begin
            ovf_a = '0;
            if (!pulse_reg)
            begin
                sub_a      = '0;
                pulse_next = 1'b1;
            end
            else
            begin
                dist_next  = dist_sat;
                pulse_next = 1'b0;
            end
        end

        // free-running timer
        sub_next  = sub_a + 1'b1;
        wrap      = &sub_a;
        ovf_inc   = {1'b0, ovf_a} + 1'b1;
        ovf_next  = ovf_a;
        busy_next = busy_reg;
        tmo       = 1'b0;
        if (wrap)
        begin
            if (ovf_inc > {1'b0, cfg.timeout_overflows})
            begin
                sub_next   = '0;
                ovf_next   = '0;
                busy_next  = 1'b0;
                pulse_next = 1'b0;
                tmo        = 1'b1;
            end
            else
            begin
                ovf_next = ovf_inc[OVF_W-1:0];
            end
        end

        // trigger pulse
        tl_a = trig_left_reg;
        if (start_request && !busy_next && (trig_left_reg == '0))
        begin
            tl_a = (cfg.trigger_ticks == '0) ? TRIG_W'(1) : cfg.trigger_ticks;
        end
        trig           = (tl_a != '0);
        trig_left_next = tl_a;
        if (trig)
        begin
            trig_left_next = tl_a - 1'b1;
            if (trig_left_next == '0)
            begin
                busy_next = 1'b1;
            end
        end

        res.trigger_out    = trig;
        res.busy_res       = busy_next || (trig_left_next != '0) || trig;
        res.distance_valid = meas;
        res.distance_cm    = dist_next;
        res.timed_out      = tmo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg       <= '0;
            ovf_reg       <= '0;
            busy_reg      <= 1'b0;
            pulse_reg     <= 1'b0;
            prev_echo_reg <= 1'b0;
            trig_left_reg <= '0;
            dist_reg      <= '0;
        end
        else if (step)
        begin
            sub_reg       <= sub_next;
            ovf_reg       <= ovf_next;
            busy_reg      <= busy_next;
            pulse_reg     <= pulse_next;
            prev_echo_reg <= echo_level;
            trig_left_reg <= trig_left_next;
            dist_reg      <= dist_next;
        end
    end

endmodule

// ===== rtl/ultrasonic_echo_ranger.sv =====
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle, sustained while results are taken
// the tick state update and the ticks-by-reciprocal multiply happen in the same cycle
// reset: asynchronous, active low; clears counters, flags, distance and both
// handshake stages; configuration returns to 730, 17986 and 240
// top level of the ultrasonic echo ranger; depends on uer_pkg and uer_core
`timescale 1ns / 1ps

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int SUB_COUNT_BITS = SUB_COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  echo_level,
    input  logic                  start_request,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic                  trigger_out,
    output logic                  busy_res,
    output logic                  distance_valid,
    output logic [DIST_W-1:0]     distance_cm,
    output logic                  timed_out
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    logic echo_reg;
    logic start_reg;
    logic out_valid_reg;
    res_t out_reg;
    res_t res;
    logic step;

    assign step       = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_overflows <= TIMEOUT_RST;
            cfg_reg.scale_reciprocal  <= SCALE_RST;
            cfg_reg.trigger_ticks     <= TRIG_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_overflows <= cfg_data[OVF_W-1:0];
                CFG_SCALE:   cfg_reg.scale_reciprocal  <= cfg_data[SCALE_W-1:0];
                CFG_TRIGGER: cfg_reg.trigger_ticks     <= cfg_data[TRIG_W-1:0];
                default:     cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            echo_reg  <= echo_level;
            start_reg <= start_request;
        end
    end

    uer_core #(
        .SUB_COUNT_BITS (SUB_COUNT_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .echo_level    (echo_reg),
        .start_request (start_reg),
        .cfg           (cfg_reg),
        .res           (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= res;
        end
    end

    assign result_valid   = out_valid_reg;
    assign trigger_out    = out_reg.trigger_out;
    assign busy_res       = out_reg.busy_res;
    assign distance_valid = out_reg.distance_valid;
    assign distance_cm    = out_reg.distance_cm;
    assign timed_out      = out_reg.timed_out;

endmodule

// ===== rtl/uer_checker.sv =====
// port-level checks on the ultrasonic echo ranger, bound to the top level
// depends on uer_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uer_checker
    import uer_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              item_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic              trigger_out,
    input logic              busy_res,
    input logic [DIST_W-1:0] distance_cm,
    input logic              timed_out
);

    logic stalled;
    logic trig_shown;
    logic tmo_shown;

    assign stalled    = result_valid && !result_ready;
    assign trig_shown = result_valid && trigger_out;
    assign tmo_shown  = result_valid && timed_out;

    // an empty result stage never stalls the input side
    `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !result_valid, item_ready, "stalled when empty")

    // a driven trigger always reports busy
    `ASSERT_IMPLY(a_trig_busy, clk, rst_n, trig_shown, busy_res, "trigger without busy")

    // a timeout drops busy unless the trigger is driven on the same tick
    `ASSERT_IMPLY(a_tmo_idle, clk, rst_n, tmo_shown, busy_res == trigger_out, "busy on timeout")

    // a stalled item holds its distance
    `ASSERT_NEXT(a_hold, clk, rst_n, stalled, result_valid && $stable(distance_cm), "item changed")

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (.*);
